### sv/pll_speed_angle_tracker_defines.svh
// Assertion macros for the angle tracker sequencer (pst_ctrl).
// Each macro expects clk and rst in scope where it is used.
`ifndef PLL_SPEED_ANGLE_TRACKER_DEFINES_SVH
`define PLL_SPEED_ANGLE_TRACKER_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define PST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define PST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/pst_pkg.sv
// Shared types, register indexes and helper functions for the angle tracker.
// Used by pst_ctrl, pst_datapath and the top level.
package pst_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned ClampInW = 36;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_INTEGRAL_GAIN      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PROPORTIONAL_GAIN  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SPEED_FILTER_COEFF = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SPEED_LIMIT        = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ANGLE_STEP_FACTOR  = 3'd4;

  // Register reset values
  localparam logic [15:0] FILTER_COEFF_RESET = 16'd32768;
  localparam logic [28:0] SPEED_LIMIT_RESET  = 29'd536870911;
  localparam logic [31:0] STEP_FACTOR_RESET  = 32'd34185;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_I,
    ST_ADD_I,
    ST_DIFF,
    ST_MUL_F,
    ST_ADD_F,
    ST_MUL_A,
    ST_DONE
  } state_t;

  // One strobe per datapath step
  typedef struct packed {
    logic load;
    logic mul_i;
    logic add_i;
    logic diff;
    logic mul_f;
    logic add_f;
    logic mul_a;
    logic finish;
  } pst_cmd_t;

  // Clamp a wide signed value to plus or minus lim
  function automatic logic signed [29:0] clamp_sym(input logic signed [ClampInW-1:0] v,
                                                   input logic [28:0] lim);
    logic signed [ClampInW-1:0] hi;
    logic signed [ClampInW-1:0] lo;
    hi = $signed({{(ClampInW-29){1'b0}}, lim});
    lo = -hi;
    if (v > hi) begin
      return hi[29:0];
    end else if (v < lo) begin
      return lo[29:0];
    end
    return v[29:0];
  endfunction

endpackage

### sv/pst_ctrl.sv
// Sequencer for the angle tracker: steps one item through the datapath.
// Depends on pst_pkg and the assertion macros header.
`include "pll_speed_angle_tracker_defines.svh"

module pst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  output logic              result_valid,
  input  logic              result_stall,
  output pst_pkg::pst_cmd_t cmd
);
  import pst_pkg::*;

  state_t state;
  state_t state_next;
  logic   result_valid_next;
  logic   slot_free;

  assign slot_free = !result_valid || !result_stall;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (item_valid) state_next = ST_MUL_I;
      ST_MUL_I: state_next = ST_ADD_I;
      ST_ADD_I: state_next = ST_DIFF;
      ST_DIFF:  state_next = ST_MUL_F;
      ST_MUL_F: state_next = ST_ADD_F;
      ST_ADD_F: state_next = ST_MUL_A;
      ST_MUL_A: state_next = ST_DONE;
      ST_DONE:  if (slot_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs: datapath strobes and handshake
  always_comb begin
    cmd        = '0;
    item_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        cmd.load   = item_valid;
      end
      ST_MUL_I: cmd.mul_i  = 1'b1;
      ST_ADD_I: cmd.add_i  = 1'b1;
      ST_DIFF:  cmd.diff   = 1'b1;
      ST_MUL_F: cmd.mul_f  = 1'b1;
      ST_ADD_F: cmd.add_f  = 1'b1;
      ST_MUL_A: cmd.mul_a  = 1'b1;
      ST_DONE:  cmd.finish = slot_free;
      default:  cmd        = '0;
    endcase
  end

  // Hold the result until its transfer, raise it when an item finishes
  always_comb begin
    result_valid_next = result_valid;
    if (cmd.finish) begin
      result_valid_next = 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid_next = 1'b0;
    end
  end

  `PST_ASSERT_NEXT(a_load_starts, cmd.load, state == ST_MUL_I, "accepted item did not start")
  `PST_ASSERT_SAME(a_finish_free, cmd.finish, !result_valid || !result_stall,
                   "result overwritten while stalled")
  `PST_ASSERT_NEXT(a_finish_valid, cmd.finish, result_valid, "finished item not presented")

endmodule

### sv/pst_datapath.sv
// Datapath of the angle tracker: configuration registers, PI loop, filter, angle.
// Depends on pst_pkg; driven by strobes from pst_ctrl.
module pst_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  pst_pkg::pst_cmd_t                  cmd,
  input  logic                               cfg_write,
  input  logic [pst_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [pst_pkg::CfgDataW-1:0]       cfg_data,
  input  logic signed [15:0]                 phase_error,
  input  logic                               closed_loop,
  output logic [15:0]                        rotor_angle,
  output logic signed [29:0]                 rotor_speed,
  output logic signed [29:0]                 integrator_value,
  output logic                               angle_drives_motor
);
  import pst_pkg::*;

  // Configuration
  logic [15:0] integral_gain;
  logic [23:0] proportional_gain;
  logic [15:0] speed_filter_coeff;
  logic [28:0] speed_limit;
  logic [31:0] angle_step_factor;

  // Loop state
  logic signed [29:0] integrator;
  logic signed [29:0] speed_estimate;
  logic [15:0]        angle_estimate;

  // Per-item work registers
  logic signed [15:0] err;
  logic               closed;
  logic signed [32:0] prod_i;
  logic signed [40:0] prod_p;
  logic signed [32:0] diff;
  logic signed [49:0] prod_f;
  logic [15:0]        inc;

  logic signed [ClampInW-1:0] integ_sum;
  logic signed [ClampInW-1:0] speed_sum;
  logic signed [47:0]         prod_a;
  logic [15:0]                angle_next;

  assign integ_sum = ClampInW'(integrator) + ClampInW'($signed(prod_i[32:15]));
  assign speed_sum = ClampInW'(speed_estimate) + ClampInW'($signed(prod_f[49:15]));
  assign prod_a    = 48'(speed_estimate) * 48'($signed({1'b0, angle_step_factor}));
  assign angle_next = angle_estimate + inc;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_gain      <= '0;
      proportional_gain  <= '0;
      speed_filter_coeff <= FILTER_COEFF_RESET;
      speed_limit        <= SPEED_LIMIT_RESET;
      angle_step_factor  <= STEP_FACTOR_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_INTEGRAL_GAIN:      integral_gain      <= cfg_data[15:0];
        REG_PROPORTIONAL_GAIN:  proportional_gain  <= cfg_data[23:0];
        REG_SPEED_FILTER_COEFF: speed_filter_coeff <= cfg_data[15:0];
        REG_SPEED_LIMIT:        speed_limit        <= cfg_data[28:0];
        REG_ANGLE_STEP_FACTOR:  angle_step_factor  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Update loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      integrator     <= '0;
      speed_estimate <= '0;
      angle_estimate <= '0;
    end else begin
      if (cmd.add_i) integrator     <= clamp_sym(integ_sum, speed_limit);
      if (cmd.add_f) speed_estimate <= clamp_sym(speed_sum, speed_limit);
      if (cmd.finish) angle_estimate <= angle_next;
    end
  end

  // Step the item through products and sums
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err    <= phase_error;
      closed <= closed_loop;
    end
    if (cmd.mul_i) begin
      prod_i <= 33'(err) * 33'($signed({1'b0, integral_gain}));
      prod_p <= 41'(err) * 41'($signed({1'b0, proportional_gain}));
    end
    if (cmd.diff) begin
      diff <= 33'($signed(prod_p[40:15])) + 33'(integrator) - 33'(speed_estimate);
    end
    if (cmd.mul_f) begin
      prod_f <= 50'(diff) * 50'($signed({1'b0, speed_filter_coeff}));
    end
    if (cmd.mul_a) begin
      inc <= prod_a[47:32];
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rotor_angle        <= angle_next;
      rotor_speed        <= speed_estimate;
      integrator_value   <= integrator;
      angle_drives_motor <= closed;
    end
  end

endmodule

### sv/pll_speed_angle_tracker.sv
// PI phase-locked-loop speed and angle tracker.
// One item in flight; a new item is taken only once the last leaves ST_DONE.
// Each item passes through a chain of three dependent
// registered multiplies (integral, filter, angle step) and their sums.
// Reset: synchronous; loop state clears to zero, registers take defaults.
module pll_speed_angle_tracker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic signed [15:0]            phase_error,
  input  logic                          closed_loop,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [15:0]                   rotor_angle,
  output logic signed [29:0]            rotor_speed,
  output logic signed [29:0]            integrator_value,
  output logic                          angle_drives_motor,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pst_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [pst_pkg::CfgDataW-1:0]  cfg_data
);
  import pst_pkg::*;

  pst_cmd_t cmd;

  // Accept a configuration transfer every cycle
  assign cfg_ready = 1'b1;

  pst_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd)
  );

  pst_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .cfg_write          (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .phase_error        (phase_error),
    .closed_loop        (closed_loop),
    .rotor_angle        (rotor_angle),
    .rotor_speed        (rotor_speed),
    .integrator_value   (integrator_value),
    .angle_drives_motor (angle_drives_motor)
  );

endmodule
